// File: rtl/core/gsa_pkg.sv
// Shared types and constants for the gaussian splat accumulator.
// Used by gsa_grid and gaussian_splat_accumulator_core; depends on nothing.
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int MAX_ROWS   = 128;
    localparam int MAX_COLS   = 128;
    localparam int MAX_RADIUS = 4;

    localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W     = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

    localparam int CELL_W     = 64;
    localparam int TAP_W      = 17;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int NUM_TAPS   = 5;

    localparam logic [TAP_W-1:0] TAP_ONE = 17'd65536;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_3     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_4     = 3'd7;

    // Item function codes
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_SPLAT = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Result kinds
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] data;
    } t_wr_req;

endpackage

// File: rtl/core/gsa_grid.sv
// Grid cell memory: one write port, one registered read port.
// Depends on gsa_pkg for depth, address width and the write request type.
`timescale 1ns / 1ps

module gsa_grid
    import gsa_pkg::*;
(
    input  logic              i_clk,
    input  t_wr_req           i_wr,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [GRID_DEPTH];
    logic [CELL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/gaussian_splat_accumulator_core.sv
// Gaussian splat accumulator: sequencer, shared multiplier and cell update.
// Depends on gsa_pkg and instantiates gsa_grid for the cell memory.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-----------------------------------
//  item in   | start, busy (take: start&!busy)| i_func, i_row_center, i_col_center,
//            |                                | i_weight, i_last_of_batch
//  result    | o_result_valid (one cycle)     | o_result_kind, o_cell_value
//  config    | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
// A clear writes all GRID_DEPTH (16384) cells, one cell written per cycle.
// A splat forms the weight*tap product once per kernel row, then runs each
// in-bounds cell through the CELL, ADDR, MLO, MHI and WR steps and leaves each
// out-of-bounds cell after CELL, all through the one 32x17 multiplier and the grid memory.
// An out-of-bounds read returns zero after CELL; others pass ADDR, RWAIT and ROUT.
// Reset runs the same clearing pass; busy stays high meanwhile.
// Results cannot be stalled: each one is shown for exactly one cycle.
`timescale 1ns / 1ps

module gaussian_splat_accumulator_core
    import gsa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic signed [15:0]    i_row_center,
    input  logic signed [15:0]    i_col_center,
    input  logic [WEIGHT_W-1:0]   i_weight,
    input  logic                  i_last_of_batch,
    output logic                  o_result_valid,
    output logic                  o_result_kind,
    output logic [CELL_W-1:0]     o_cell_value,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [9:0] {
        ST_CLR   = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_ROW   = 10'b00_0000_0100,
        ST_CELL  = 10'b00_0000_1000,
        ST_ADDR  = 10'b00_0001_0000,
        ST_MLO   = 10'b00_0010_0000,
        ST_MHI   = 10'b00_0100_0000,
        ST_WR    = 10'b00_1000_0000,
        ST_RWAIT = 10'b01_0000_0000,
        ST_ROUT  = 10'b10_0000_0000
    } t_state;

    // Configuration
    logic [7:0]       r_rows;
    logic [7:0]       r_cols;
    logic [2:0]       r_rad;
    logic [TAP_W-1:0] r_tap [NUM_TAPS];

    // Control
    t_state             r_state, n_state;
    logic signed [3:0]  r_dy, n_dy;
    logic signed [3:0]  r_dx, n_dx;
    logic [ADDR_W-1:0]  r_sweep, n_sweep;
    logic               r_is_read, n_is_read;
    logic               r_res_valid, n_res_valid;

    // Payload
    logic signed [15:0]  r_rc, r_cc;
    logic [WEIGHT_W-1:0] r_weight;
    logic                r_last;
    logic [47:0]         r_p1;
    logic [ADDR_W-1:0]   r_cofs;
    logic [ADDR_W-1:0]   r_addr;
    logic [48:0]         r_plo;
    logic [32:0]         r_phi;
    logic [47:0]         r_add;
    logic                r_res_kind;
    logic [CELL_W-1:0]   r_res_value;

    logic [31:0]         mul_a;
    logic [TAP_W-1:0]    mul_b;
    logic [48:0]         mul_p;
    logic signed [16:0]  row_sum, col_sum;
    logic                in_bnd;
    logic [2:0]          ady, adx;
    logic [TAP_W-1:0]    tap_y, tap_x;
    logic signed [3:0]   rad_s, neg_rad;
    logic [63:0]         prod_full;
    logic [CELL_W:0]     sum_ext;
    logic [CELL_W-1:0]   sum_sat;
    logic [CELL_W-1:0]   rd_data;
    t_wr_req             wr;
    logic                accept;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Configuration writes, values clamped to their usable range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 8'(MAX_ROWS);
            r_cols <= 8'(MAX_COLS);
            r_rad  <= 3'd0;
            r_tap[0] <= TAP_ONE;
            for (int i = 1; i < NUM_TAPS; i++) begin
                r_tap[i] <= '0;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GRID_ROWS: begin
                    r_rows <= (i_cfg_data[7:0] > 8'(MAX_ROWS)) ? 8'(MAX_ROWS)
                                                               : i_cfg_data[7:0];
                end
                CFG_GRID_COLS: begin
                    r_cols <= (i_cfg_data[7:0] > 8'(MAX_COLS)) ? 8'(MAX_COLS)
                                                               : i_cfg_data[7:0];
                end
                CFG_RADIUS: begin
                    r_rad <= (i_cfg_data[2:0] > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS)
                                                                : i_cfg_data[2:0];
                end
                CFG_TAP_0, CFG_TAP_1, CFG_TAP_2, CFG_TAP_3, CFG_TAP_4: begin
                    r_tap[3'(i_cfg_index - CFG_TAP_0)] <=
                        (i_cfg_data > TAP_ONE) ? TAP_ONE : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Kernel position, bounds and taps
    assign rad_s   = $signed({1'b0, r_rad});
    assign neg_rad = 4'sd0 - rad_s;
    assign row_sum = 17'(r_rc) + 17'(r_dy);
    assign col_sum = 17'(r_cc) + 17'(r_dx);
    assign in_bnd  = !row_sum[16] && !col_sum[16]
                     && (row_sum[15:0] < 16'(r_rows))
                     && (col_sum[15:0] < 16'(r_cols));
    assign ady     = r_dy[3] ? 3'(-r_dy) : r_dy[2:0];
    assign adx     = r_dx[3] ? 3'(-r_dx) : r_dx[2:0];
    assign tap_y   = r_tap[ady];
    assign tap_x   = r_tap[adx];

    // Shared multiplier: operands picked by the sequencer step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_ROW: begin
                mul_a = r_weight;
                mul_b = tap_y;
            end
            ST_CELL: begin
                mul_a = 32'(col_sum[COL_W-1:0]);
                mul_b = 17'(r_rows);
            end
            ST_ADDR: begin
                mul_a = r_p1[31:0];
                mul_b = tap_x;
            end
            ST_MLO: begin
                mul_a = 32'(r_p1[47:32]);
                mul_b = tap_x;
            end
            default: begin
            end
        endcase
    end

    assign mul_p = 49'(mul_a) * 49'(mul_b);

    // weight * tap_y * tap_x stays below 2^64; drop 16 fraction bits later
    assign prod_full = {r_phi[31:0], 32'd0} + 64'(r_plo);
    assign sum_ext   = {1'b0, rd_data} + 65'(r_add);
    assign sum_sat   = sum_ext[CELL_W] ? {CELL_W{1'b1}} : sum_ext[CELL_W-1:0];

    always_comb begin
        wr.we   = (r_state == ST_CLR) || (r_state == ST_WR);
        wr.addr = (r_state == ST_CLR) ? r_sweep : r_addr;
        wr.data = (r_state == ST_CLR) ? '0 : sum_sat;
    end

    gsa_grid u_grid (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_rd_addr (r_addr),
        .o_rd_data (rd_data)
    );

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_dy        = r_dy;
        n_dx        = r_dx;
        n_sweep     = r_sweep;
        n_is_read   = r_is_read;
        n_res_valid = 1'b0;
        case (r_state)
            ST_CLR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(GRID_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    case (i_func)
                        FUNC_CLEAR: begin
                            n_state = ST_CLR;
                            n_sweep = '0;
                        end
                        FUNC_SPLAT: begin
                            n_state   = ST_ROW;
                            n_dy      = neg_rad;
                            n_dx      = neg_rad;
                            n_is_read = 1'b0;
                        end
                        FUNC_READ: begin
                            n_state   = ST_CELL;
                            n_dy      = 4'sd0;
                            n_dx      = 4'sd0;
                            n_is_read = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ROW: begin
                n_state = ST_CELL;
            end
            ST_ADDR: begin
                n_state = r_is_read ? ST_RWAIT : ST_MLO;
            end
            ST_MLO: begin
                n_state = ST_MHI;
            end
            ST_MHI: begin
                n_state = ST_WR;
            end
            ST_RWAIT: begin
                n_state = ST_ROUT;
            end
            ST_ROUT: begin
                n_state     = ST_IDLE;
                n_res_valid = 1'b1;
            end
            ST_CELL, ST_WR: begin
                if (r_state == ST_CELL && in_bnd) begin
                    n_state = ST_ADDR;
                end else if (r_is_read) begin
                    // out-of-bounds read: return zero
                    n_state     = ST_IDLE;
                    n_res_valid = 1'b1;
                end else if (r_dx != rad_s) begin
                    n_dx    = r_dx + 4'sd1;
                    n_state = ST_CELL;
                end else begin
                    n_dx = neg_rad;
                    if (r_dy != rad_s) begin
                        n_dy    = r_dy + 4'sd1;
                        n_state = ST_ROW;
                    end else begin
                        n_state     = ST_IDLE;
                        n_res_valid = r_last;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_dy        <= 4'sd0;
            r_dx        <= 4'sd0;
            r_sweep     <= '0;
            r_is_read   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dy        <= n_dy;
            r_dx        <= n_dx;
            r_sweep     <= n_sweep;
            r_is_read   <= n_is_read;
            r_res_valid <= n_res_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rc     <= i_row_center;
            r_cc     <= i_col_center;
            r_weight <= i_weight;
            r_last   <= i_last_of_batch;
        end
        case (r_state)
            ST_ROW: begin
                r_p1 <= mul_p[47:0];
            end
            ST_CELL: begin
                r_cofs      <= mul_p[ADDR_W-1:0];
                r_res_kind  <= r_is_read ? KIND_READ : KIND_DONE;
                r_res_value <= '0;
            end
            ST_ADDR: begin
                r_addr <= ADDR_W'(row_sum[ROW_W-1:0]) + r_cofs;
                r_plo  <= mul_p;
            end
            ST_MLO: begin
                r_phi <= mul_p[32:0];
            end
            ST_MHI: begin
                r_add <= prod_full[63:16];
            end
            ST_ROUT: begin
                r_res_kind  <= KIND_READ;
                r_res_value <= rd_data;
            end
            default: begin
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_result_kind  = r_res_kind;
    assign o_cell_value   = r_res_value;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |=> !r_res_valid)
        else $error("result strobe held for more than one cycle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !wr.we)
        else $error("grid written while idle");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_func == FUNC_CLEAR || i_func == FUNC_SPLAT
                    || i_func == FUNC_READ)) |=> busy)
        else $error("item taken but block not busy");

    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WR) |-> (32'(r_addr) < 32'(GRID_DEPTH)))
        else $error("cell write outside grid");

    a_done_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res_kind == KIND_DONE) |-> (r_res_value == '0))
        else $error("batch done result carries data");
`endif

endmodule

// File: tb/sv/tb_gaussian_splat_accumulator_core.sv
// Self-checking testbench for gaussian_splat_accumulator_core: a grid mirror
// scoreboard, directed and random splat/read/clear items, register phases.
// Depends on gsa_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_gaussian_splat_accumulator_core;
    import gsa_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam int         STALL_LIMIT = 100000;
    localparam int         QUIET_SPAN  = 420;

    typedef struct packed {
        logic              kind;
        logic [CELL_W-1:0] value;
    } cell_beat_t;

    // Mirror of the grid and its registers; holds the beats still owed.
    class splat_mirror;
        bit [CELL_W-1:0] cells [GRID_DEPTH];
        int              rows_in_use;
        int              cols_in_use;
        int              reach;
        bit [TAP_W-1:0]  taps [NUM_TAPS];
        cell_beat_t      owed_beats [$];
        int              errors;

        function new();
            foreach (cells[i]) cells[i] = '0;
            rows_in_use = MAX_ROWS;
            cols_in_use = MAX_COLS;
            reach       = 0;
            foreach (taps[i]) taps[i] = '0;
            taps[0]     = TAP_ONE;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_GRID_ROWS: rows_in_use = (data[7:0] > MAX_ROWS) ? MAX_ROWS : int'(data[7:0]);
                CFG_GRID_COLS: cols_in_use = (data[7:0] > MAX_COLS) ? MAX_COLS : int'(data[7:0]);
                CFG_RADIUS:    reach = (data[2:0] > MAX_RADIUS) ? MAX_RADIUS : int'(data[2:0]);
                default:       taps[int'(idx) - int'(CFG_TAP_0)] = (data > TAP_ONE) ? TAP_ONE : data;
            endcase
        endfunction

        function bit locate(int r, int c, output int addr);
            addr = 0;
            if (r < 0 || c < 0 || r >= rows_in_use || c >= cols_in_use) return 0;
            addr = r + c * rows_in_use;
            return addr < GRID_DEPTH;
        endfunction

        function void splat(int r, int c, bit [WEIGHT_W-1:0] w);
            int          addr;
            bit [63:0]   prod;
            bit [63:0]   addend;
            bit [64:0]   sum;
            for (int dy = -reach; dy <= reach; dy++) begin
                for (int dx = -reach; dx <= reach; dx++) begin
                    if (!locate(r + dy, c + dx, addr)) continue;
                    prod   = 64'(taps[dy < 0 ? -dy : dy]) * 64'(taps[dx < 0 ? -dx : dx]);
                    addend = (64'(w) * prod) >> 16;
                    sum    = {1'b0, cells[addr]} + {1'b0, addend};
                    cells[addr] = sum[64] ? '1 : sum[63:0];
                end
            end
        endfunction

        function void take_item(logic [1:0] func, logic signed [15:0] row,
                                logic signed [15:0] col, logic [WEIGHT_W-1:0] w,
                                logic last);
            int         addr;
            cell_beat_t beat;
            case (func)
                FUNC_CLEAR: foreach (cells[i]) cells[i] = '0;
                FUNC_SPLAT: begin
                    splat(int'(row), int'(col), w);
                    if (last) begin
                        beat.kind  = KIND_DONE;
                        beat.value = '0;
                        owed_beats.push_back(beat);
                    end
                end
                FUNC_READ: begin
                    beat.kind  = KIND_READ;
                    beat.value = locate(int'(row), int'(col), addr) ? cells[addr] : '0;
                    owed_beats.push_back(beat);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 40) $display("ERROR @%0t: %s", $time, msg);
        endtask

        task check_result(logic kind, logic [CELL_W-1:0] value);
            cell_beat_t want;
            if (owed_beats.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d value %h", kind, value));
                return;
            end
            want = owed_beats.pop_front();
            if (kind !== want.kind)
                report_mismatch($sformatf("result kind %0d, want %0d", kind, want.kind));
            if (value !== want.value)
                report_mismatch($sformatf("cell value %h, want %h", value, want.value));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            i_func;
    logic signed [15:0]    i_row_center;
    logic signed [15:0]    i_col_center;
    logic [WEIGHT_W-1:0]   i_weight;
    logic                  i_last_of_batch;
    logic                  o_result_valid;
    logic                  o_result_kind;
    logic [CELL_W-1:0]     o_cell_value;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    splat_mirror sb;
    int          quiet_cycles;
    int          rows_span;
    int          cols_span;
    int          reach_now;
    int          last_r;
    int          last_c;

    gaussian_splat_accumulator_core DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_row_center    (i_row_center),
        .i_col_center    (i_col_center),
        .i_weight        (i_weight),
        .i_last_of_batch (i_last_of_batch),
        .o_result_valid  (o_result_valid),
        .o_result_kind   (o_result_kind),
        .o_cell_value    (o_cell_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Check results before noting a new item: a result may share the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (o_result_valid) sb.check_result(o_result_kind, o_cell_value);
            if (start && !busy)
                sb.take_item(i_func, i_row_center, i_col_center, i_weight, i_last_of_batch);
            if (i_cfg_valid && o_cfg_ready) sb.write_reg(i_cfg_index, i_cfg_data);
            if (o_result_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("** gaussian_splat_accumulator_core: FAILED **");
        $finish;
    end

    task automatic send_item(logic [1:0] f, int r, int c, logic [WEIGHT_W-1:0] w, logic last);
        @(negedge i_clk);
        start           <= 1'b1;
        i_func          <= f;
        i_row_center    <= 16'(r);
        i_col_center    <= 16'(c);
        i_weight        <= w;
        i_last_of_batch <= last;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // Drop start and scramble the fields at each falling edge of the rest.
    task automatic rest(int n);
        repeat (n) begin
            @(negedge i_clk);
            start           <= 1'b0;
            i_func          <= 2'($urandom);
            i_row_center    <= 16'($urandom);
            i_col_center    <= 16'($urandom);
            i_weight        <= $urandom;
            i_last_of_batch <= 1'($urandom);
        end
    endtask

    task automatic drain_results();
        rest(1);
        while (sb.owed_beats.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // Hold off until the block is idle, then load every register.
    task automatic configure(int rows, int cols, int rad, int t0, int t1, int t2, int t3, int t4);
        drain_results();
        repeat (QUIET_SPAN) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        cfg_write(CFG_GRID_ROWS, {9'($urandom), 8'(rows)});
        cfg_write(CFG_GRID_COLS, {9'($urandom), 8'(cols)});
        cfg_write(CFG_RADIUS,    {14'($urandom), 3'(rad)});
        cfg_write(CFG_TAP_0, 17'(t0));
        cfg_write(CFG_TAP_1, 17'(t1));
        cfg_write(CFG_TAP_2, 17'(t2));
        cfg_write(CFG_TAP_3, 17'(t3));
        cfg_write(CFG_TAP_4, 17'(t4));
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        rows_span = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        cols_span = (cols > MAX_COLS) ? MAX_COLS : cols;
        reach_now = (rad > MAX_RADIUS) ? MAX_RADIUS : rad;
        last_r    = rows_span / 2;
        last_c    = cols_span / 2;
    endtask

    function automatic int tap_pick();
        case ($urandom_range(5))
            0:       return 0;
            1:       return int'(TAP_ONE);
            2:       return 17'h1_FFFF;
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_pick();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(0, 32'h0003_0000);
            default: return 32'h0001_0000 + $urandom_range(0, 255);
        endcase
    endfunction

    // Coordinate around the grid, reaching one past the kernel radius beyond each edge.
    function automatic int near(int span, int rad);
        return int'($urandom_range(0, span + 2 * rad + 1)) - rad - 1;
    endfunction

    function automatic int jitter(int rad);
        return int'($urandom_range(0, 2 * rad)) - rad;
    endfunction

    task automatic run_phase(int count, int gap_pct);
        int         counted;
        int         sel;
        int         r;
        int         c;
        logic [1:0] f;
        counted = 0;
        while (counted < count) begin
            // Every third block of 40 items runs without sender gaps.
            if (((counted / 40) % 3 != 2) && $urandom_range(99) < gap_pct)
                rest($urandom_range(1, 8));
            if ($urandom_range(199) == 0) drain_results();
            sel = $urandom_range(99);
            if (sel < 45) begin
                if ($urandom_range(2) == 0) begin
                    r = last_r + jitter(reach_now);
                    c = last_c + jitter(reach_now);
                end else begin
                    r = near(rows_span, reach_now);
                    c = near(cols_span, reach_now);
                end
                last_r = r;
                last_c = c;
                send_item(FUNC_SPLAT, r, c, weight_pick(), $urandom_range(3) == 0);
            end else if (sel < 80) begin
                if ($urandom_range(1)) begin
                    r = last_r + jitter(reach_now + 1);
                    c = last_c + jitter(reach_now + 1);
                end else begin
                    r = int'($urandom_range(0, rows_span + 1)) - 1;
                    c = int'($urandom_range(0, cols_span + 1)) - 1;
                end
                send_item(FUNC_READ, r, c, $urandom, 1'($urandom));
            end else if (sel < 92) begin
                f = 2'($urandom_range(1, 3));
                send_item(f, $urandom, $urandom, $urandom, 1'($urandom));
                if (f == FUNC_NONE) continue;
            end else if (sel < 93) begin
                send_item(FUNC_CLEAR, $urandom, $urandom, $urandom, 1'($urandom));
            end else begin
                send_item(FUNC_NONE, $urandom, $urandom, $urandom, 1'($urandom));
                continue;
            end
            counted++;
        end
    endtask

    initial begin
        sb              = new();
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_CLEAR;
        i_row_center    = '0;
        i_col_center    = '0;
        i_weight        = '0;
        i_last_of_batch = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_GRID_ROWS;
        i_cfg_data      = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: corners, fully outside splats, bounds of reads, ignored marks.
        configure(5, 7, 4, 65536, 17'h1_FFFF, 32768, 1, 0);
        send_item(FUNC_READ,  0, 0, 32'h0, 1'b0);
        send_item(FUNC_SPLAT, 0, 0, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_SPLAT, 4, 6, 32'h0001_0000, 1'b0);
        send_item(FUNC_SPLAT, -32768, 32767, 32'h1, 1'b1);
        send_item(FUNC_SPLAT, 32767, -32768, 32'h8000_0000, 1'b0);
        send_item(FUNC_SPLAT, 2, 3, 32'h0001_2345, 1'b0);
        send_item(FUNC_READ,  0, 0, 32'h0, 1'b0);
        send_item(FUNC_READ,  4, 6, 32'h0, 1'b0);
        send_item(FUNC_READ,  2, 3, 32'h0, 1'b0);
        send_item(FUNC_READ,  4, 0, 32'h0, 1'b0);
        send_item(FUNC_READ,  5, 0, 32'h0, 1'b0);
        send_item(FUNC_READ,  0, 7, 32'h0, 1'b0);
        send_item(FUNC_READ,  -1, 0, 32'h0, 1'b0);
        send_item(FUNC_READ,  0, -1, 32'h0, 1'b0);
        send_item(FUNC_READ,  32767, -32768, 32'h0, 1'b0);
        send_item(FUNC_NONE,  -1, -1, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_READ,  1, 1, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_CLEAR, 1, 1, 32'hFFFF_FFFF, 1'b1);
        send_item(FUNC_READ,  2, 3, 32'h0, 1'b0);
        send_item(FUNC_SPLAT, 1, 1, 32'h0002_0000, 1'b1);
        send_item(FUNC_READ,  1, 1, 32'h0, 1'b0);
        send_item(FUNC_READ,  0, 4, 32'h0, 1'b0);
        send_item(FUNC_SPLAT, 2, 2, 32'h0, 1'b1);
        send_item(FUNC_READ,  2, 2, 32'h0, 1'b0);

        // Empty grids and an oversized radius.
        configure(0, 128, 7, 65536, 65536, 65536, 65536, 65536);
        run_phase(8, 0);
        configure(1, 0, 1, 65536, 40000, 0, 0, 0);
        run_phase(8, 0);

        configure(16, 12, 2, tap_pick(), tap_pick(), tap_pick(), tap_pick(), tap_pick());
        run_phase(260, 34);
        configure(255, 128, 4, 65536, tap_pick(), tap_pick(), 17'h1_FFFF, tap_pick());
        run_phase(130, 54);
        configure(3, 200, 1, tap_pick(), tap_pick(), tap_pick(), tap_pick(), tap_pick());
        run_phase(130, 54);
        configure(1, 1, 3, tap_pick(), tap_pick(), tap_pick(), tap_pick(), tap_pick());
        run_phase(100, 0);
        configure(40, 33, $urandom_range(0, 7), tap_pick(), tap_pick(), tap_pick(),
                  tap_pick(), tap_pick());
        run_phase(160, 0);

        drain_results();
        repeat (500) @(posedge i_clk);
        if (sb.errors == 0)
            $display("** gaussian_splat_accumulator_core: PASSED **");
        else
            $display("** gaussian_splat_accumulator_core: FAILED **");
        $finish;
    end

endmodule
